>>> rtl/gpio_pkg.sv
// ----------------------------------------------------------------------------
// GPIO port package
// Item formats, register offsets, lock key steps and field spreading helpers
// shared by the channel interface users and the port register block.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_pkg;

    localparam int PIN_COUNT_DEF = 16;
    localparam int PIN_MAX       = 16;

    // access kinds
    localparam logic KIND_READ  = 1'b0;
    localparam logic KIND_WRITE = 1'b1;

    // register word offsets
    localparam logic [3:0] REG_MODE     = 4'd0;
    localparam logic [3:0] REG_TYPE     = 4'd1;
    localparam logic [3:0] REG_SPEED    = 4'd2;
    localparam logic [3:0] REG_PULL     = 4'd3;
    localparam logic [3:0] REG_IN       = 4'd4;
    localparam logic [3:0] REG_OUT      = 4'd5;
    localparam logic [3:0] REG_SETRESET = 4'd6;
    localparam logic [3:0] REG_LOCK     = 4'd7;
    localparam logic [3:0] REG_AFLOW    = 4'd8;
    localparam logic [3:0] REG_AFHIGH   = 4'd9;

    // lock key sequence steps
    localparam logic [1:0] KEY_WAIT_FIRST = 2'd0;
    localparam logic [1:0] KEY_WAIT_CLEAR = 2'd1;
    localparam logic [1:0] KEY_WAIT_FINAL = 2'd2;
    localparam logic [1:0] KEY_LOCKED     = 2'd3;

    // position of the lock key bit in the lock register
    localparam int LOCK_KEY_BIT = 16;

    typedef struct packed {
        logic        kind;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } gpio_req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] drive_levels;
        logic        lock_active;
    } gpio_rsp_t;

    // widen a 16-pin mask to 2-bit fields
    function automatic logic [31:0] spread2(input logic [15:0] m);
        logic [31:0] r;
        for (int p = 0; p < 16; p++)
        begin
            r[2*p +: 2] = {2{m[p]}};
        end
        return r;
    endfunction

    // widen an 8-pin mask to 4-bit fields
    function automatic logic [31:0] spread4(input logic [7:0] m);
        logic [31:0] r;
        for (int p = 0; p < 8; p++)
        begin
            r[4*p +: 4] = {4{m[p]}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/gpio_chan_if.sv
// ----------------------------------------------------------------------------
// GPIO item channel
// Valid/ready channel carrying one item per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpio_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> rtl/gpio_port_register_block.sv
// Pipeline: the request item is registered at its accepting edge and its result
// item is registered, and offered, when the request leaves the input register.
// Throughput: one item per cycle while results are taken; an item's state
// update is done as it leaves the input register, so each sees its predecessor.
// Reset (rst_n low, asynchronous): all port registers, the lock and the key
// sequence clear to zero; both pipeline stages empty.
// ----------------------------------------------------------------------------
// GPIO port register block
// 16-pin port register file with mode, type, speed, pull, input and output
// data, bit set/reset, configuration lock and alternate function selects.
// ----------------------------------------------------------------------------
`default_nettype none

module gpio_port_register_block
    import gpio_pkg::*;
#(
    parameter int PIN_COUNT = PIN_COUNT_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    gpio_chan_if.sink     req,
    gpio_chan_if.source   rsp
);

    // pins beyond PIN_COUNT read zero and ignore writes
    localparam logic [15:0] PinMask = 16'((33'd1 << PIN_COUNT) - 33'd1);

    // ------------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------------
    logic      in_valid_reg;
    gpio_req_t in_item_reg;
    logic      out_valid_reg;
    gpio_rsp_t out_item_reg;
    logic      advance;

    // move the held item on when the result register is free or being emptied
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;

    assign rsp.valid   = out_valid_reg;
    assign rsp.payload = out_item_reg;

    // ------------------------------------------------------------------------
    // Port state
    // ------------------------------------------------------------------------
    logic [31:0] mode_reg,      mode_next;
    logic [15:0] type_reg,      type_next;
    logic [31:0] speed_reg,     speed_next;
    logic [31:0] pull_reg,      pull_next;
    logic [15:0] latch_reg,     latch_next;
    logic [31:0] aflow_reg,     aflow_next;
    logic [31:0] afhigh_reg,    afhigh_next;
    logic [16:0] lock_reg,      lock_next;
    logic [1:0]  key_step_reg,  key_step_next;
    logic [31:0] read_data;

    logic [15:0] locked_pins;
    logic [15:0] free_pins;
    logic [31:0] mask2;
    logic [31:0] mask_aflow;
    logic [31:0] mask_afhigh;
    logic [31:0] wdata;
    logic [15:0] lock_pins;
    logic        lock_key;
    logic        lock_same;

    // lock only bites once the key bit is set
    assign locked_pins = lock_reg[LOCK_KEY_BIT] ? lock_reg[15:0] : 16'd0;
    assign free_pins   = PinMask & ~locked_pins;
    assign mask2       = spread2(free_pins);
    assign mask_aflow  = spread4(free_pins[7:0]);
    assign mask_afhigh = spread4(free_pins[15:8]);

    assign wdata     = in_item_reg.write_data;
    assign lock_pins = wdata[15:0] & PinMask;
    assign lock_key  = wdata[LOCK_KEY_BIT];
    assign lock_same = (lock_pins == lock_reg[15:0]);

    always_comb
    begin
        mode_next     = mode_reg;
        type_next     = type_reg;
        speed_next    = speed_reg;
        pull_next     = pull_reg;
        latch_next    = latch_reg;
        aflow_next    = aflow_reg;
        afhigh_next   = afhigh_reg;
        lock_next     = lock_reg;
        key_step_next = key_step_reg;
        read_data     = 32'd0;

        if (in_item_reg.kind == KIND_WRITE)
        begin
            case (in_item_reg.reg_index)
                REG_MODE:     mode_next  = (mode_reg & ~mask2) | (wdata & mask2);
                REG_TYPE:     type_next  = (type_reg & ~free_pins) | (wdata[15:0] & free_pins);
                REG_SPEED:    speed_next = (speed_reg & ~mask2) | (wdata & mask2);
                REG_PULL:     pull_next  = (pull_reg & ~mask2) | (wdata & mask2);
                REG_OUT:      latch_next = wdata[15:0] & PinMask;
                REG_SETRESET:
                begin
                    // set wins over reset on the same pin
                    latch_next = ((latch_reg & ~wdata[31:16]) | wdata[15:0]) & PinMask;
                end
                REG_LOCK:
                begin
                    if (key_step_reg != KEY_LOCKED)
                    begin
                        if (key_step_reg == KEY_WAIT_CLEAR && !lock_key && lock_same)
                        begin
                            key_step_next = KEY_WAIT_FINAL;
                            lock_next     = {1'b0, lock_pins};
                        end
                        else if (key_step_reg == KEY_WAIT_FINAL && lock_key && lock_same)
                        begin
                            key_step_next = KEY_LOCKED;
                            lock_next     = {1'b1, lock_pins};
                        end
                        else
                        begin
                            // broken pattern: restart, counting this write if keyed
                            key_step_next = lock_key ? KEY_WAIT_CLEAR : KEY_WAIT_FIRST;
                            lock_next     = {1'b0, lock_pins};
                        end
                    end
                end
                REG_AFLOW:    aflow_next  = (aflow_reg & ~mask_aflow) | (wdata & mask_aflow);
                REG_AFHIGH:   afhigh_next = (afhigh_reg & ~mask_afhigh) | (wdata & mask_afhigh);
                default:      ;
            endcase
        end
        else
        begin
            case (in_item_reg.reg_index)
                REG_MODE:   read_data = mode_reg;
                REG_TYPE:   read_data = {16'd0, type_reg};
                REG_SPEED:  read_data = speed_reg;
                REG_PULL:   read_data = pull_reg;
                REG_IN:     read_data = {16'd0, in_item_reg.pin_levels & PinMask};
                REG_OUT:    read_data = {16'd0, latch_reg};
                REG_LOCK:   read_data = {15'd0, lock_reg};
                REG_AFLOW:  read_data = aflow_reg;
                REG_AFHIGH: read_data = afhigh_reg;
                default:    read_data = 32'd0;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= 32'd0;
            type_reg      <= 16'd0;
            speed_reg     <= 32'd0;
            pull_reg      <= 32'd0;
            latch_reg     <= 16'd0;
            aflow_reg     <= 32'd0;
            afhigh_reg    <= 32'd0;
            lock_reg      <= 17'd0;
            key_step_reg  <= KEY_WAIT_FIRST;
        end
        else
        begin
            // hold the input stage unless it drains or refills
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                type_reg      <= type_next;
                speed_reg     <= speed_next;
                pull_reg      <= pull_next;
                latch_reg     <= latch_next;
                aflow_reg     <= aflow_next;
                afhigh_reg    <= afhigh_next;
                lock_reg      <= lock_next;
                key_step_reg  <= key_step_next;
            end
            else if (rsp.ready)
            begin
                // drop the delivered result
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: no reset needed
    always_ff @(posedge clk)
    begin
        if (req.ready && req.valid)
        begin
            in_item_reg <= req.payload;
        end
        if (advance)
        begin
            out_item_reg.read_data    <= read_data;
            out_item_reg.drive_levels <= latch_next;
            out_item_reg.lock_active  <= lock_next[LOCK_KEY_BIT];
        end
    end

endmodule

`default_nettype wire
